// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ssid_pkg.sv =====
// types and constants of the sorted set block
// no dependencies
`default_nettype none

package ssid_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;
  localparam int OUT_W    = 8;

  // operation codes carried on in_tuser
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_DEL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/ssid_cell.sv =====
// one slot of the sorted chain: holds a value, compares it, shifts with neighbors
// depends on ssid_pkg
`default_nettype none

module ssid_cell
  import ssid_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire cell_cmd_t            cmd,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire                       left_lt,
  input  wire logic signed [VALUE_W-1:0] left_entry,
  input  wire                       left_valid,
  input  wire logic signed [VALUE_W-1:0] right_entry,
  input  wire                       right_valid,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      valid,
  output logic                      lt,
  output logic                      eq
);

  logic signed [VALUE_W-1:0] entry_r, entry_nxt;
  logic                      valid_r, valid_nxt;

  // compare against the broadcast value
  assign lt    = valid_r && (entry_r < value);
  assign eq    = valid_r && (entry_r == value);
  assign entry = entry_r;
  assign valid = valid_r;

  // cells below the insert or delete point keep; the rest shift
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (cmd.ins) begin
      valid_nxt = left_valid;
      if (!lt) begin
        entry_nxt = left_lt ? value : left_entry;
      end
    end else if (cmd.del) begin
      valid_nxt = right_valid;
      if (!lt) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== src/sorted_set_insert_delete.sv =====
// Sorted set of signed 32-bit values, ascending, no duplicates, at most
// CAPACITY entries. Each input item (in_tuser 0 add, 1 delete) gives one
// result item with a status (ok, full, duplicate, empty, not found) and the
// count after the item, low 4 bits. Every cell of the
// chain compares its value with the item's value at once and shifts with its
// neighbor in the same edge, and the result sits in an output register, so an
// item is accepted each cycle unless the output is stalled. No clearing pass.
// depends on ssid_pkg and ssid_cell
`default_nettype none

module sorted_set_insert_delete
  import ssid_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire [VALUE_W-1:0] in_tdata,  // [31:0] value
  input  wire              in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [OUT_W-1:0] out_tdata   // [2:0] status, [6:3] count, [7] zero
);

  localparam int FILL_W = $clog2(CAPACITY + 1);

  logic                      accept;
  logic signed [VALUE_W-1:0] value;
  cell_cmd_t                 cmd;
  logic                      is_full, is_empty, dup;
  status_t                   status;

  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]          out_data_r;

  logic signed [VALUE_W-1:0] c_entry [CAPACITY];
  logic [CAPACITY-1:0]       c_valid, c_lt, c_eq;

  assign accept = in_tvalid && in_tready;
  assign value  = $signed(in_tdata);

  // chain of cells, cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      l_lt, l_valid, r_valid;
    logic signed [VALUE_W-1:0] l_entry, r_entry;
    if (i == 0) begin : g_first
      assign l_lt    = 1'b1;
      assign l_valid = 1'b1;
      assign l_entry = value;
    end else begin : g_mid
      assign l_lt    = c_lt[i-1];
      assign l_valid = c_valid[i-1];
      assign l_entry = c_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_entry = c_entry[i];
    end else begin : g_body
      assign r_valid = c_valid[i+1];
      assign r_entry = c_entry[i+1];
    end
    ssid_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .value       (value),
      .left_lt     (l_lt),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .entry       (c_entry[i]),
      .valid       (c_valid[i]),
      .lt          (c_lt[i]),
      .eq          (c_eq[i])
    );
  end

  // decide the outcome of the item
  assign is_full  = (fill_r >= FILL_W'(CAPACITY));
  assign is_empty = (fill_r == '0);
  assign dup      = |c_eq;

  always_comb begin
    cmd      = '0;
    status   = ST_OK;
    fill_nxt = fill_r;
    if (in_tuser == FUNC_ADD) begin
      if (is_full) begin
        status = ST_FULL;
      end else if (dup) begin
        status = ST_DUP;
      end else begin
        cmd.ins  = accept;
        fill_nxt = fill_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status = ST_EMPTY;
      end else if (!dup) begin
        status = ST_NOTFOUND;
      end else begin
        cmd.del  = accept;
        fill_nxt = fill_r - 1'b1;
      end
    end
  end

  // output register parts the two sides
  assign in_tready     = !out_valid_r || out_tready;
  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {1'b0, COUNT_W'(fill_nxt), status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== src/ssid_checker.sv =====
// port-level checks on the sorted set block, bound to its top level
// depends on ssid_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ssid_checker
  import ssid_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input wire               clk,
  input wire               rst_n,
  input wire               in_tvalid,
  input wire               in_tready,
  input wire               out_tvalid,
  input wire               out_tready,
  input wire [OUT_W-1:0]   out_tdata
);

  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  logic [STATUS_W-1:0] out_st;
  logic [COUNT_W-1:0]  out_cnt;
  logic                stall, res_full, res_empty;

  // result fields and conditions
  assign out_st    = out_tdata[STATUS_W-1:0];
  assign out_cnt   = out_tdata[STATUS_W +: COUNT_W];
  assign stall     = out_tvalid && !out_tready;
  assign res_full  = out_tvalid && (out_st == ST_FULL);
  assign res_empty = out_tvalid && (out_st == ST_EMPTY);

  // a stalled result holds its data
  `ASSERT_CLK(a_hold, clk, rst_n, stall |=> $stable(out_tdata), "result changed while stalled")

  // an accepted item shows a result in the next cycle
  `ASSERT_CLK(a_result, clk, rst_n, in_tvalid && in_tready |=> out_tvalid, "no result after an item")

  // a full status reports a full count
  `ASSERT_CLK(a_full_cnt, clk, rst_n, res_full |-> out_cnt == CAP_CNT, "full status with wrong count")

  // an empty status reports zero
  `ASSERT_CLK(a_empty_cnt, clk, rst_n, res_empty |-> out_cnt == '0, "empty status, nonzero count")

  // reset clears the result channel
  `ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind sorted_set_insert_delete ssid_checker #(.CAPACITY(CAPACITY)) u_ssid_checker (.*);

`default_nettype wire

// ===== verif/tb_sorted_set_insert_delete.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the sorted set insert/delete block
// drives add/delete items, predicts status and count, checks every result item
// depends on ssid_pkg and sorted_set_insert_delete

module tb_sorted_set_insert_delete;
  import ssid_pkg::*;

  localparam int SET_CAP      = 8;
  localparam int RANDOM_ITEMS = 1950;
  localparam int PHASE_LEN    = 40;
  localparam int POOL_SIZE    = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_IDLE     = 13;

  typedef struct {
    logic                 func;
    logic [VALUE_W-1:0]   value;
    bit                   typed;
    status_t              status;
    logic [COUNT_W-1:0]   count;
  } stim_row_t;

  typedef struct {
    status_t            status;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata   = '0;  // [31:0] value
  logic               in_tuser   = 1'b0;  // [0] func
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;  // [2:0] status, [6:3] count, [7] zero

  // predicted contents of the set, ascending signed order
  logic signed [VALUE_W-1:0] held_vals [SET_CAP];
  int                        held_cnt = 0;

  set_result_t        pending_results [$];
  stim_row_t          directed_rows [$];
  logic [VALUE_W-1:0] value_pool [POOL_SIZE];
  int                 err_count = 0;
  int                 cycles    = 0;
  bit                 tx_burst  = 1'b0;

  sorted_set_insert_delete #(
    .CAPACITY (SET_CAP)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // sorted set update: full is checked before the duplicate search
  function automatic void update_set(input logic func, input logic [VALUE_W-1:0] val,
                                     output status_t st, output logic [COUNT_W-1:0] cnt);
    int pos;
    int hit;
    pos = 0;
    hit = -1;
    for (int i = 0; i < held_cnt; i++) begin
      if (held_vals[i] == val) hit = i;
      if (held_vals[i] < $signed(val)) pos = i + 1;
    end
    if (func == FUNC_ADD) begin
      if (held_cnt >= SET_CAP) begin
        st = ST_FULL;
      end else if (hit >= 0) begin
        st = ST_DUP;
      end else begin
        for (int i = held_cnt; i > pos; i--) held_vals[i] = held_vals[i-1];
        held_vals[pos] = val;
        held_cnt++;
        st = ST_OK;
      end
    end else if (held_cnt == 0) begin
      st = ST_EMPTY;
    end else if (hit < 0) begin
      st = ST_NOTFOUND;
    end else begin
      for (int i = hit; i < held_cnt - 1; i++) held_vals[i] = held_vals[i+1];
      held_cnt--;
      st = ST_OK;
    end
    cnt = held_cnt[COUNT_W-1:0];
  endfunction

  task automatic add_row(input logic func, input logic [VALUE_W-1:0] val, input bit typed,
                         input status_t st, input logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.func   = func;
    row.value  = val;
    row.typed  = typed;
    row.status = st;
    row.count  = cnt;
    directed_rows.push_back(row);
  endtask

  // send one item; optionally hold off until every result has arrived
  task automatic send_item(input stim_row_t row, input bit hold);
    int          gap;
    set_result_t want;
    set_result_t calc;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (hold && gap == 0) gap = 1;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (hold) while (pending_results.size() != 0) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.value;
    in_tuser  <= row.func;
    do @(posedge clk); while (!in_tready);
    update_set(row.func, row.value, calc.status, calc.count);
    if (row.typed) begin
      want.status = row.status;
      want.count  = row.count;
    end else begin
      want = calc;
    end
    pending_results.push_back(want);
  endtask

  // random value: present entry, pool value, extreme, or fully random word
  function automatic logic [VALUE_W-1:0] pick_value();
    int c;
    c = $urandom_range(0, 9);
    if (c < 4 && held_cnt > 0) return held_vals[$urandom_range(0, held_cnt - 1)];
    if (c < 8) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (c == 8) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom();
  endfunction

  // result side: random stalls per item, with stretches of none
  int rx_stall   = 0;
  int rx_mode_ct = 0;
  bit rx_burst   = 1'b0;

  always @(posedge clk) begin
    set_result_t want;
    status_t     got_st;
    logic [COUNT_W-1:0] got_cnt;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_st  = status_t'(out_tdata[STATUS_W-1:0]);
        got_cnt = out_tdata[STATUS_W +: COUNT_W];
        if (pending_results.size() == 0) begin
          report_error($sformatf("unexpected result item: status %0d count %0d",
                                 got_st, got_cnt));
        end else begin
          want = pending_results.pop_front();
          if (got_st !== want.status || got_cnt !== want.count)
            report_error($sformatf("mismatch: expected status %0d count %0d, got status %0d count %0d",
                                   want.status, want.count, got_st, got_cnt));
        end
        if (rx_mode_ct == 0) begin
          rx_burst   = ($urandom_range(0, 3) == 0);
          rx_mode_ct = $urandom_range(10, 60);
        end
        rx_mode_ct--;
        rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (rx_stall > 0) begin
        out_tready <= 1'b0;
        rx_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t row;
    int        add_pct;
    bit        hold;

    // reset and table walk: extremes, every status, full and empty edges
    add_row(FUNC_DEL, 32'd5,          1'b1, ST_EMPTY,    4'd0);
    add_row(FUNC_ADD, 32'h8000_0000,  1'b1, ST_OK,       4'd1);
    add_row(FUNC_ADD, 32'h7FFF_FFFF,  1'b1, ST_OK,       4'd2);
    add_row(FUNC_ADD, 32'd0,          1'b0, ST_OK,       4'd0);
    add_row(FUNC_ADD, 32'h8000_0000,  1'b1, ST_DUP,      4'd3);
    add_row(FUNC_DEL, 32'd5,          1'b1, ST_NOTFOUND, 4'd3);
    add_row(FUNC_ADD, 32'hFFFF_FFFF,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_ADD, 32'd1,          1'b0, ST_OK,       4'd0);
    add_row(FUNC_ADD, 32'h7FFF_FFFE,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_ADD, 32'h8000_0001,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_ADD, 32'd5,          1'b0, ST_OK,       4'd0);
    add_row(FUNC_ADD, 32'd7,          1'b1, ST_FULL,     4'd8);
    // full wins over duplicate
    add_row(FUNC_ADD, 32'd0,          1'b1, ST_FULL,     4'd8);
    add_row(FUNC_DEL, 32'h7FFF_FFFF,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'h8000_0000,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'd0,          1'b0, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'd0,          1'b1, ST_NOTFOUND, 4'd5);
    add_row(FUNC_DEL, 32'hFFFF_FFFF,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'd1,          1'b0, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'h7FFF_FFFE,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'h8000_0001,  1'b0, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'd5,          1'b1, ST_OK,       4'd0);
    add_row(FUNC_DEL, 32'd5,          1'b1, ST_EMPTY,    4'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i], 1'b0);

    // random part in phases that lean to filling, draining or balance
    add_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      hold = 1'b0;
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: add_pct = 80;
          1: add_pct = 20;
          default: add_pct = 50;
        endcase
        for (int k = 0; k < POOL_SIZE; k++)
          value_pool[k] = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 40) - 20);
        tx_burst = ($urandom_range(0, 3) == 0);
        hold     = (n == 0) || ($urandom_range(0, 3) == 0);
      end
      row.func   = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_DEL;
      row.value  = pick_value();
      row.typed  = 1'b0;
      row.status = ST_OK;
      row.count  = '0;
      send_item(row, hold);
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ssid_pkg.sv
src/ssid_cell.sv
src/sorted_set_insert_delete.sv
src/ssid_checker.sv
verif/tb_sorted_set_insert_delete.sv
